### sv/dpft_pkg.sv
// Shared types and constants for the demand-paging FIFO translator.
// No dependencies; imported by dpft_split, the translator top and the testbench.
package dpft_pkg;

  // Address and table geometry
  localparam int VA_W       = 32;
  localparam int PA_W       = 24;
  localparam int PT_ENTRIES = 4096;
  localparam int PT_AW      = $clog2(PT_ENTRIES);
  localparam int MAX_FRAMES = 256;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int PT_W       = FRAME_W + 1;
  localparam int CNT_W      = 32;

  // Configuration widths and limits
  localparam int BITS_W     = 5;
  localparam int FC_W       = 9;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int OFF_MIN    = 4;
  localparam int OFF_MAX    = 16;
  localparam int OFF_W      = OFF_MAX;

  localparam logic [BITS_W-1:0] OFF_BITS_RST = BITS_W'(12);
  localparam logic [FC_W-1:0]   FC_RST       = FC_W'(MAX_FRAMES);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_FRAME_COUNT = 1'b1
  } cfg_idx_t;

  // Address split result
  typedef struct packed {
    logic [PT_AW-1:0]  vpn;
    logic [OFF_W-1:0]  offset;
    logic [BITS_W-1:0] bits;
    logic              oor;
  } split_t;

endpackage

### sv/dpft_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module dpft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/dpft_split.sv
// Splits a virtual address into page number and offset under the clamped
// page size. Depends on dpft_pkg.
module dpft_split (
  input  logic [dpft_pkg::VA_W-1:0]   va,
  input  logic [dpft_pkg::BITS_W-1:0] cfg_bits,
  output dpft_pkg::split_t            split
);
  import dpft_pkg::*;

  logic [BITS_W-1:0] bits_eff;
  logic [VA_W-1:0]   vpn_full;
  logic [OFF_W:0]    off_mask;

  // clamp offset width to the supported page sizes
  always_comb begin
    if (cfg_bits < BITS_W'(OFF_MIN)) begin
      bits_eff = BITS_W'(OFF_MIN);
    end else if (cfg_bits > BITS_W'(OFF_MAX)) begin
      bits_eff = BITS_W'(OFF_MAX);
    end else begin
      bits_eff = cfg_bits;
    end
  end

  assign vpn_full = va >> bits_eff;
  assign off_mask = ((OFF_W+1)'(1) << bits_eff) - (OFF_W+1)'(1);

  // page beyond the table when any bit above the table index is set
  assign split.vpn    = vpn_full[PT_AW-1:0];
  assign split.oor    = |vpn_full[VA_W-1:PT_AW];
  assign split.offset = va[OFF_W-1:0] & off_mask[OFF_W-1:0];
  assign split.bits   = bits_eff;

endmodule

### sv/demand_paging_fifo_translator_top.sv
// Demand-paging translator with FIFO (round-robin) frame replacement.
// Result: accepted in S_IDLE, looked up in S_LOOK and registered once the output register is free.
// A new item is taken only in S_IDLE, after the last one has posted its result;
// an eviction adds S_MAP, as the page-table RAM takes the victim invalidate and the
// new mapping through its single write port in consecutive cycles. A stalled result
// that holds the output register keeps the lookup waiting in S_LOOK.
// Reset: a clearing pass over all 4096 page-table entries (input stalled).
module demand_paging_fifo_translator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [dpft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpft_pkg::CFG_W-1:0]      cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dpft_pkg::VA_W-1:0]       in_virtual_address,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dpft_pkg::PA_W-1:0]       out_physical_address,
  output logic                            out_hit,
  output logic                            out_evicted,
  output logic [dpft_pkg::PT_AW-1:0]      out_victim_page,
  output logic [dpft_pkg::FRAME_W-1:0]    out_frame,
  output logic                            out_out_of_range,
  output logic [dpft_pkg::CNT_W-1:0]      out_hit_total,
  output logic [dpft_pkg::CNT_W-1:0]      out_fault_total
);
  import dpft_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_MAP} state_t;

  // configuration registers
  logic [BITS_W-1:0] cfg_bits_r;
  logic [FC_W-1:0]   cfg_fc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bits_r <= OFF_BITS_RST;
      cfg_fc_r   <= FC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS: cfg_bits_r <= cfg_wdata[BITS_W-1:0];
        CFG_FRAME_COUNT: cfg_fc_r   <= cfg_wdata[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame count, 1..MAX_FRAMES
  logic [FC_W-1:0] fc_eff;
  always_comb begin
    if (cfg_fc_r == '0) begin
      fc_eff = FC_W'(1);
    end else if (cfg_fc_r > FC_W'(MAX_FRAMES)) begin
      fc_eff = FC_W'(MAX_FRAMES);
    end else begin
      fc_eff = cfg_fc_r;
    end
  end

  // address split
  split_t split;
  dpft_split u_split (
    .va       (in_virtual_address),
    .cfg_bits (cfg_bits_r),
    .split    (split)
  );

  // state and registers
  state_t             state_r, state_nxt;
  logic [PT_AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [PT_AW-1:0]   vpn_r, vpn_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic               oor_r, oor_nxt;
  logic [FRAME_W-1:0] frm_r, frm_nxt;
  logic [FC_W-1:0]    fused_r, fused_nxt;
  logic [FRAME_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]   flt_cnt_r, flt_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]    out_pa_r, out_pa_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [PT_AW-1:0]   out_victim_r, out_victim_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_oor_r, out_oor_nxt;
  logic [CNT_W-1:0]   out_hits_r, out_hits_nxt;
  logic [CNT_W-1:0]   out_flts_r, out_flts_nxt;

  // memory ports
  logic               pt_we, pt_re;
  logic [PT_AW-1:0]   pt_waddr;
  logic [PT_W-1:0]    pt_wdata, pt_rdata;
  logic               own_we, own_re;
  logic [FRAME_W-1:0] own_waddr, own_raddr;
  logic [PT_AW-1:0]   own_wdata, own_rdata;

  // page table: {valid, frame}
  dpft_ram #(.WIDTH(PT_W), .DEPTH(PT_ENTRIES)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (split.vpn),
    .rdata (pt_rdata)
  );

  // frame owner table: page held by each frame
  dpft_ram #(.WIDTH(PT_AW), .DEPTH(MAX_FRAMES)) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .re    (own_re),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  // handshakes
  logic in_take, out_free;
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // replacement pointer wrapped to the current frame count
  logic [FRAME_W-1:0] rp_eff;
  logic [FC_W-1:0]    rp_inc;
  assign rp_eff = ({1'b0, rp_r} >= fc_eff) ? '0 : rp_r;
  assign rp_inc = {1'b0, rp_eff} + FC_W'(1);

  // owner of the replacement frame is read alongside the page table
  assign pt_re     = in_take;
  assign own_re    = in_take;
  assign own_raddr = rp_eff;

  logic [FRAME_W-1:0] sel_frm;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    vpn_nxt        = vpn_r;
    off_nxt        = off_r;
    bits_nxt       = bits_r;
    oor_nxt        = oor_r;
    frm_nxt        = frm_r;
    fused_nxt      = fused_r;
    rp_nxt         = rp_r;
    hit_cnt_nxt    = hit_cnt_r;
    flt_cnt_nxt    = flt_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_pa_nxt     = out_pa_r;
    out_hit_nxt    = out_hit_r;
    out_ev_nxt     = out_ev_r;
    out_victim_nxt = out_victim_r;
    out_frame_nxt  = out_frame_r;
    out_oor_nxt    = out_oor_r;
    out_hits_nxt   = out_hits_r;
    out_flts_nxt   = out_flts_r;
    pt_we          = 1'b0;
    pt_waddr       = vpn_r;
    pt_wdata       = {1'b1, frm_r};
    own_we         = 1'b0;
    own_waddr      = rp_eff;
    own_wdata      = vpn_r;
    sel_frm        = '0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // sweep invalidating every page-table entry
      S_CLEAR: begin
        pt_we        = 1'b1;
        pt_waddr     = clr_addr_r;
        pt_wdata     = '0;
        clr_addr_nxt = clr_addr_r + PT_AW'(1);
        if (clr_addr_r == PT_AW'(PT_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // capture the split address; memory reads issued this edge
      S_IDLE: begin
        if (in_take) begin
          vpn_nxt   = split.vpn;
          off_nxt   = split.offset;
          bits_nxt  = split.bits;
          oor_nxt   = split.oor;
          state_nxt = S_LOOK;
        end
      end

      // decide out-of-range / hit / fill / evict and post the result
      S_LOOK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = 1'b0;
          out_ev_nxt     = 1'b0;
          out_victim_nxt = '0;
          out_oor_nxt    = oor_r;
          state_nxt      = S_IDLE;
          if (oor_r) begin
            sel_frm = '0;
          end else if (pt_rdata[PT_W-1]) begin
            sel_frm     = pt_rdata[FRAME_W-1:0];
            out_hit_nxt = 1'b1;
            if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
          end else begin
            if (flt_cnt_r != '1) flt_cnt_nxt = flt_cnt_r + CNT_W'(1);
            if (fused_r < fc_eff) begin
              // free frame still available
              sel_frm   = fused_r[FRAME_W-1:0];
              fused_nxt = fused_r + FC_W'(1);
              pt_we     = 1'b1;
              pt_wdata  = {1'b1, sel_frm};
            end else begin
              // evict oldest: invalidate victim now, map in S_MAP
              sel_frm        = rp_eff;
              out_ev_nxt     = 1'b1;
              out_victim_nxt = own_rdata;
              pt_we          = 1'b1;
              pt_waddr       = own_rdata;
              pt_wdata       = '0;
              rp_nxt         = (rp_inc >= fc_eff) ? '0 : rp_inc[FRAME_W-1:0];
              state_nxt      = S_MAP;
            end
            own_we    = 1'b1;
            own_waddr = sel_frm;
          end
          frm_nxt       = sel_frm;
          out_frame_nxt = sel_frm;
          out_pa_nxt    = oor_r ? '0 : ((PA_W'(sel_frm) << bits_r) | PA_W'(off_r));
          out_hits_nxt  = hit_cnt_nxt;
          out_flts_nxt  = flt_cnt_nxt;
        end
      end

      // write the new mapping after an eviction
      S_MAP: begin
        pt_we     = 1'b1;
        pt_waddr  = vpn_r;
        pt_wdata  = {1'b1, frm_r};
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      fused_r     <= '0;
      rp_r        <= '0;
      hit_cnt_r   <= '0;
      flt_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      fused_r     <= fused_nxt;
      rp_r        <= rp_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      flt_cnt_r   <= flt_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    vpn_r        <= vpn_nxt;
    off_r        <= off_nxt;
    bits_r       <= bits_nxt;
    oor_r        <= oor_nxt;
    frm_r        <= frm_nxt;
    out_pa_r     <= out_pa_nxt;
    out_hit_r    <= out_hit_nxt;
    out_ev_r     <= out_ev_nxt;
    out_victim_r <= out_victim_nxt;
    out_frame_r  <= out_frame_nxt;
    out_oor_r    <= out_oor_nxt;
    out_hits_r   <= out_hits_nxt;
    out_flts_r   <= out_flts_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_hit              = out_hit_r;
  assign out_evicted          = out_ev_r;
  assign out_victim_page      = out_victim_r;
  assign out_frame            = out_frame_r;
  assign out_out_of_range     = out_oor_r;
  assign out_hit_total        = out_hits_r;
  assign out_fault_total      = out_flts_r;

  // checks
  a_fused_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fused_r <= FC_W'(MAX_FRAMES))
    else $error("frames-used count beyond frame limit");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> !out_hit_r && !out_oor_r)
    else $error("eviction flagged on a hit or out-of-range item");

  a_hits_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit counter went backwards");

  a_result_from_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOOK))
    else $error("result posted outside the lookup step");

endmodule

### dv/tb_demand_paging_fifo_translator_top.sv
// Self-checking testbench for demand_paging_fifo_translator_top.
// Depends on dpft_pkg and the translator RTL; a behavioural page table with
// round-robin replacement predicts every result, checked in arrival order.
module tb_demand_paging_fifo_translator_top;
  import dpft_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int EXP_AW         = 4;
  localparam int EXP_DEPTH      = 1 << EXP_AW;

  // One translation result as seen on the output ports
  typedef struct packed {
    logic [PA_W-1:0]    pa;
    logic               hit;
    logic               evicted;
    logic [PT_AW-1:0]   victim;
    logic [FRAME_W-1:0] frame;
    logic               oor;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   fault_total;
  } xlat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = CFG_OFFSET_BITS;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VA_W-1:0]      in_virtual_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PA_W-1:0]      out_physical_address;
  logic                 out_hit;
  logic                 out_evicted;
  logic [PT_AW-1:0]     out_victim_page;
  logic [FRAME_W-1:0]   out_frame;
  logic                 out_out_of_range;
  logic [CNT_W-1:0]     out_hit_total;
  logic [CNT_W-1:0]     out_fault_total;

  demand_paging_fifo_translator_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_physical_address (out_physical_address),
    .out_hit              (out_hit),
    .out_evicted          (out_evicted),
    .out_victim_page      (out_victim_page),
    .out_frame            (out_frame),
    .out_out_of_range     (out_out_of_range),
    .out_hit_total        (out_hit_total),
    .out_fault_total      (out_fault_total)
  );

  always #6 clk = ~clk;

  // Predicted page table, frame ownership and registers
  logic               pt_mapped [PT_ENTRIES];
  logic [FRAME_W-1:0] pt_frame_no [PT_ENTRIES];
  logic [PT_AW-1:0]   owner_of_frame [MAX_FRAMES];
  int unsigned        frames_filled;
  int unsigned        next_victim_frame;
  logic [CNT_W-1:0]   hit_tally;
  logic [CNT_W-1:0]   fault_tally;
  logic [BITS_W-1:0]  off_bits_reg;
  logic [FC_W-1:0]    frame_count_reg;

  // Expected results, in the order the items were accepted
  xlat_t              exp_fifo [EXP_DEPTH];
  logic [EXP_AW-1:0]  exp_wr_ptr = '0;
  logic [EXP_AW-1:0]  exp_rd_ptr = '0;

  int fail_count;
  int items_sent;
  int reg_writes;
  int n_hit, n_fault, n_evict, n_oor;
  int burst_left;
  int idle_cycles;

  // Receiver stall control
  bit hold_req;
  int hold_left;
  int seg_left;
  int stall_pct;

  function automatic logic [EXP_AW-1:0] exp_level();
    return exp_wr_ptr - exp_rd_ptr;
  endfunction

  function automatic void exp_store(input xlat_t r);
    exp_fifo[exp_wr_ptr] = r;
    exp_wr_ptr++;
  endfunction

  function automatic int unsigned eff_offset_bits();
    int unsigned b;
    b = off_bits_reg;
    if (b < OFF_MIN) b = OFF_MIN;
    if (b > OFF_MAX) b = OFF_MAX;
    return b;
  endfunction

  function automatic int unsigned eff_frames();
    int unsigned f;
    f = frame_count_reg;
    if (f < 1) f = 1;
    if (f > MAX_FRAMES) f = MAX_FRAMES;
    return f;
  endfunction

  // Translate one address and advance the predicted state
  function automatic xlat_t translate_va(input logic [VA_W-1:0] va);
    xlat_t         r;
    int unsigned   b;
    int unsigned   fc;
    logic [31:0]   vpn;
    logic [31:0]   offset;
    b      = eff_offset_bits();
    fc     = eff_frames();
    vpn    = va >> b;
    offset = va & ((32'd1 << b) - 32'd1);
    r      = '0;
    if (vpn >= PT_ENTRIES) begin
      r.oor = 1'b1;
    end else if (pt_mapped[vpn]) begin
      r.hit   = 1'b1;
      r.frame = pt_frame_no[vpn];
      if (hit_tally != '1) hit_tally++;
    end else begin
      if (fault_tally != '1) fault_tally++;
      if (frames_filled < fc) begin
        r.frame = FRAME_W'(frames_filled);
        frames_filled++;
      end else begin
        // all frames in use: evict the oldest loaded page
        if (next_victim_frame >= fc) next_victim_frame = 0;
        r.frame   = FRAME_W'(next_victim_frame);
        r.victim  = owner_of_frame[next_victim_frame];
        r.evicted = 1'b1;
        pt_mapped[r.victim] = 1'b0;
        next_victim_frame = (next_victim_frame + 1 >= fc) ? 0 : next_victim_frame + 1;
      end
      pt_mapped[vpn]          = 1'b1;
      pt_frame_no[vpn]        = r.frame;
      owner_of_frame[r.frame] = PT_AW'(vpn);
    end
    if (!r.oor) r.pa = PA_W'((32'(r.frame) << b) | offset);
    r.hit_total   = hit_tally;
    r.fault_total = fault_tally;
    return r;
  endfunction

  // Offer one address; paced items follow the burst and gap pattern
  task automatic send_va(input logic [VA_W-1:0] va, input bit paced);
    int gap;
    if (paced && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid           <= 1'b1;
    in_virtual_address <= va;
    forever begin
      @(negedge clk);
      if (in_stall === 1'b0) break;
      @(posedge clk);
    end
    @(posedge clk);
    exp_store(translate_va(va));
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (exp_level() != '0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OFFSET_BITS: off_bits_reg = val[BITS_W-1:0];
      CFG_FRAME_COUNT: frame_count_reg = val[FC_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Fill frames from reset settings, then hit the same pages
  task automatic test_fill_and_hit();
    send_va(32'h0000_0000, 1'b0);
    send_va(32'h0000_0FFF, 1'b0);
    send_va(32'h00FF_F123, 1'b0);
    send_va(32'h00FF_FFFF, 1'b0);
    send_va(32'h0000_1ABC, 1'b0);
  endtask

  // Pages past the table: flagged, nothing changes; the last address is the table's top page, a hit
  task automatic test_out_of_range();
    send_va(32'h0100_0000, 1'b0);
    send_va(32'hFFFF_FFFF, 1'b0);
    send_va(32'h8000_0000, 1'b0);
    send_va(32'h00FF_F000, 1'b0);
  endtask

  // Lower the frame count under live mappings: faults evict in FIFO order,
  // pages in frames above the count keep hitting
  task automatic test_eviction();
    write_reg(CFG_FRAME_COUNT, 9'd2);
    send_va(32'h0000_5000, 1'b0);
    send_va(32'h0000_1234, 1'b0);
    send_va(32'h0000_6000, 1'b0);
    send_va(32'h0000_7000, 1'b0);
    send_va(32'h0000_0000, 1'b0);
    write_reg(CFG_FRAME_COUNT, 9'd0);
    send_va(32'h0000_8000, 1'b0);
    send_va(32'h0000_1000, 1'b0);
  endtask

  // Register values outside the meaningful range clamp
  task automatic test_register_clamps();
    write_reg(CFG_OFFSET_BITS, 9'h1E0);
    write_reg(CFG_FRAME_COUNT, 9'd511);
    send_va(32'h0000_FFF5, 1'b0);
    send_va(32'h0001_0000, 1'b0);
    write_reg(CFG_OFFSET_BITS, 9'd31);
    send_va(32'h0FFF_ABCD, 1'b0);
    send_va(32'h1000_0000, 1'b0);
  endtask

  // Random addresses over several settings, mostly from a page working set
  task automatic test_random_traffic();
    int unsigned ph_bits [7] = '{4, 16, 31, 0, 9, 12, 0};
    int unsigned ph_fc   [7] = '{1, 256, 5, 511, 0, 40, 0};
    int unsigned b, fc, pool, base_vpn, vpn, roll;
    logic [VA_W-1:0] va;
    ph_bits[6] = $urandom_range(0, 31);
    ph_fc[6]   = $urandom_range(0, 511);
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_OFFSET_BITS, {4'($urandom_range(0, 15)), 5'(ph_bits[p])});
      write_reg(CFG_FRAME_COUNT, 9'(ph_fc[p]));
      b        = eff_offset_bits();
      fc       = eff_frames();
      pool     = $urandom_range(1, fc + fc / 2 + 2);
      base_vpn = $urandom_range(0, PT_ENTRIES - 1);
      for (int i = 0; i < 110; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          va = $urandom;
        end else if (roll < 12) begin
          // either side of the table end
          vpn = $urandom_range(PT_ENTRIES - 8, PT_ENTRIES + 100);
          va  = (vpn << b) | ($urandom & ((32'd1 << b) - 1));
        end else begin
          vpn = (base_vpn + $urandom_range(0, pool - 1)) % PT_ENTRIES;
          va  = (vpn << b) | ($urandom & ((32'd1 << b) - 1));
        end
        send_va(va, 1'b1);
      end
    end
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    int unsigned b;
    write_reg(CFG_FRAME_COUNT, 9'd7);
    b = eff_offset_bits();
    hold_req = 1'b1;
    repeat (2) @(posedge clk);
    for (int i = 0; i < 100; i++)
      send_va(($urandom_range(0, 15) << b) | ($urandom & ((32'd1 << b) - 1)), 1'b0);
  endtask

  // Receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 40);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (expv !== actv) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %0h, got %0h (result %0d)",
                 name, expv, actv, n_hit + n_fault + n_oor);
    end
  endfunction

  // Result checker: outputs are stable at the falling edge
  always @(negedge clk) begin
    xlat_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (exp_level() == '0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with no translation outstanding");
      end else begin
        exp_r = exp_fifo[exp_rd_ptr];
        exp_rd_ptr++;
        check_field("physical_address", 32'(exp_r.pa), 32'(out_physical_address));
        check_field("hit", 32'(exp_r.hit), 32'(out_hit));
        check_field("evicted", 32'(exp_r.evicted), 32'(out_evicted));
        check_field("victim_page", 32'(exp_r.victim), 32'(out_victim_page));
        check_field("frame", 32'(exp_r.frame), 32'(out_frame));
        check_field("out_of_range", 32'(exp_r.oor), 32'(out_out_of_range));
        check_field("hit_total", exp_r.hit_total, out_hit_total);
        check_field("fault_total", exp_r.fault_total, out_fault_total);
        if (exp_r.oor) n_oor++;
        else if (exp_r.hit) n_hit++;
        else n_fault++;
        if (exp_r.evicted) n_evict++;
      end
    end
  end

  // Watchdog: cycles with no item moving on either channel
  always @(negedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL demand_paging_fifo_translator_top");
      $finish;
    end
  end

  initial begin
    foreach (pt_mapped[i]) pt_mapped[i] = 1'b0;
    frames_filled     = 0;
    next_victim_frame = 0;
    hit_tally         = '0;
    fault_tally       = '0;
    off_bits_reg      = OFF_BITS_RST;
    frame_count_reg   = FC_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_fill_and_hit();
    test_out_of_range();
    test_eviction();
    test_register_clamps();
    test_random_traffic();
    test_backpressure();

    // drain
    in_valid <= 1'b0;
    while (exp_level() != '0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d translations: %0d hits, %0d faults (%0d evictions), %0d off-table",
             items_sent, n_hit, n_fault, n_evict, n_oor);
    $display("%0d register writes, offset widths and frame counts taken past both limits",
             reg_writes);
    if (fail_count == 0) begin
      $display("PASS demand_paging_fifo_translator_top");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAIL demand_paging_fifo_translator_top");
    end
    $finish;
  end

endmodule

### sim.f
sv/dpft_pkg.sv
sv/dpft_ram.sv
sv/dpft_split.sv
sv/demand_paging_fifo_translator_top.sv
dv/tb_demand_paging_fifo_translator_top.sv
